// File: rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared widths, register map, reset values and verdict codes for the
// password rule checker.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int COUNT_BITS_DEF = 8;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 8;
    localparam int REG_W     = 8;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;

    typedef enum logic [2:0] {
        VERDICT_VALID    = 3'd0,
        VERDICT_NONASCII = 3'd1,
        VERDICT_SHORT    = 3'd2,
        VERDICT_LONG     = 3'd3,
        VERDICT_LOWER    = 3'd4,
        VERDICT_UPPER    = 3'd5,
        VERDICT_DIGITS   = 3'd6,
        VERDICT_SPECIAL  = 3'd7
    } t_verdict;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MIN_LENGTH  = 3'd0,
        REG_MAX_LENGTH  = 3'd1,
        REG_MIN_LOWER   = 3'd2,
        REG_MIN_UPPER   = 3'd3,
        REG_MIN_DIGIT   = 3'd4,
        REG_MIN_SPECIAL = 3'd5,
        REG_RSVD_6      = 3'd6,
        REG_RSVD_7      = 3'd7
    } t_reg_idx;

    localparam logic [REG_W-1:0] RST_MIN_LENGTH  = 8'd8;
    localparam logic [REG_W-1:0] RST_MAX_LENGTH  = 8'd64;
    localparam logic [REG_W-1:0] RST_MIN_LOWER   = 8'd1;
    localparam logic [REG_W-1:0] RST_MIN_UPPER   = 8'd1;
    localparam logic [REG_W-1:0] RST_MIN_DIGIT   = 8'd1;
    localparam logic [REG_W-1:0] RST_MIN_SPECIAL = 8'd1;

    localparam logic [CHAR_W-1:0] ASCII_MAX = 8'd127;

endpackage

// File: rtl/prc_char_if.sv
// ----------------------------------------------------------------------------
// prc_char_if
// Valid/ready channel carrying one password byte per item.
// ----------------------------------------------------------------------------
interface prc_char_if
    import prc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

// File: rtl/prc_verdict_if.sv
// ----------------------------------------------------------------------------
// prc_verdict_if
// Valid/ready channel carrying one verdict and string length per item.
// ----------------------------------------------------------------------------
interface prc_verdict_if
    import prc_pkg::*;
();
    logic             valid;
    logic             ready;
    t_verdict         verdict;
    logic [LEN_W-1:0] string_length;

    modport source (output valid, output verdict, output string_length, input ready);
    modport sink   (input valid, input verdict, input string_length, output ready);
endinterface

// File: rtl/password_rule_checker.sv
// ----------------------------------------------------------------------------
// password_rule_checker
// Path: a terminator byte passes the input register, then the result register, to give its verdict.
// Throughput: 1 byte per cycle; the input register and the result register
// advance together, so only a stalled result holds the pipe.
// Reset: i_rst_n synchronous, active low; clears counters, valids and loads
// the threshold registers with their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module password_rule_checker
    import prc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    prc_char_if.sink          i_char,
    prc_verdict_if.source     o_verdict
);

    localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CMP_W-1:0] LEN_SAT = CMP_W'({LEN_W{1'b1}});

    // threshold registers
    logic [REG_W-1:0] r_min_length, r_max_length, r_min_lower;
    logic [REG_W-1:0] r_min_upper, r_min_digit, r_min_special;

    // input stage
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_byte;

    // string state
    logic                  r_nonascii;
    logic [COUNT_BITS-1:0] r_len_cnt, r_lower_cnt, r_upper_cnt;
    logic [COUNT_BITS-1:0] r_digit_cnt, r_special_cnt;

    // result stage
    logic             r_out_valid;
    t_verdict         r_verdict;
    logic [LEN_W-1:0] r_len_out;

    logic     s_adv, s_proc, s_term;
    logic     s_lower, s_upper, s_digit, s_punct, s_high;
    t_verdict s_verdict;
    logic [CMP_W-1:0] s_len_ext;
    logic [LEN_W-1:0] s_len_sat;
    t_reg_idx s_idx;
    logic     s_wr;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign s_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign s_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length  <= RST_MIN_LENGTH;
            r_max_length  <= RST_MAX_LENGTH;
            r_min_lower   <= RST_MIN_LOWER;
            r_min_upper   <= RST_MIN_UPPER;
            r_min_digit   <= RST_MIN_DIGIT;
            r_min_special <= RST_MIN_SPECIAL;
        end else if (s_wr) begin
            unique case (s_idx)
                REG_MIN_LENGTH:  r_min_length  <= pwdata[REG_W-1:0];
                REG_MAX_LENGTH:  r_max_length  <= pwdata[REG_W-1:0];
                REG_MIN_LOWER:   r_min_lower   <= pwdata[REG_W-1:0];
                REG_MIN_UPPER:   r_min_upper   <= pwdata[REG_W-1:0];
                REG_MIN_DIGIT:   r_min_digit   <= pwdata[REG_W-1:0];
                REG_MIN_SPECIAL: r_min_special <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (s_idx)
            REG_MIN_LENGTH:  prdata[REG_W-1:0] = r_min_length;
            REG_MAX_LENGTH:  prdata[REG_W-1:0] = r_max_length;
            REG_MIN_LOWER:   prdata[REG_W-1:0] = r_min_lower;
            REG_MIN_UPPER:   prdata[REG_W-1:0] = r_min_upper;
            REG_MIN_DIGIT:   prdata[REG_W-1:0] = r_min_digit;
            REG_MIN_SPECIAL: prdata[REG_W-1:0] = r_min_special;
            default: ;
        endcase
    end

    // ---------------- handshake ----------------
    // both stages move on one enable; the result slot frees when taken
    assign s_adv        = !r_out_valid || o_verdict.ready;
    assign i_char.ready = !r_in_valid || s_adv;
    assign s_proc       = r_in_valid && s_adv;
    assign s_term       = (r_in_byte == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_byte <= i_char.char_byte;
        end
    end

    // ---------------- classification ----------------
    assign s_high  = (r_in_byte > ASCII_MAX);
    assign s_lower = (r_in_byte >= 8'h61) && (r_in_byte <= 8'h7a);
    assign s_upper = (r_in_byte >= 8'h41) && (r_in_byte <= 8'h5a);
    assign s_digit = (r_in_byte >= 8'h30) && (r_in_byte <= 8'h39);
    assign s_punct = ((r_in_byte >= 8'h21) && (r_in_byte <= 8'h2f)) ||
                     ((r_in_byte >= 8'h3a) && (r_in_byte <= 8'h40)) ||
                     ((r_in_byte >= 8'h5b) && (r_in_byte <= 8'h60)) ||
                     ((r_in_byte >= 8'h7b) && (r_in_byte <= 8'h7e));

    // ---------------- verdict ----------------
    assign s_len_ext = CMP_W'(r_len_cnt);
    assign s_len_sat = (s_len_ext > LEN_SAT) ? LEN_SAT[LEN_W-1:0] : s_len_ext[LEN_W-1:0];

    always_comb begin
        priority if (r_nonascii)
            s_verdict = VERDICT_NONASCII;
        else if (s_len_ext < CMP_W'(r_min_length))
            s_verdict = VERDICT_SHORT;
        else if (s_len_ext > CMP_W'(r_max_length))
            s_verdict = VERDICT_LONG;
        else if (CMP_W'(r_lower_cnt) < CMP_W'(r_min_lower))
            s_verdict = VERDICT_LOWER;
        else if (CMP_W'(r_upper_cnt) < CMP_W'(r_min_upper))
            s_verdict = VERDICT_UPPER;
        else if (CMP_W'(r_digit_cnt) < CMP_W'(r_min_digit))
            s_verdict = VERDICT_DIGITS;
        else if (CMP_W'(r_special_cnt) < CMP_W'(r_min_special))
            s_verdict = VERDICT_SPECIAL;
        else
            s_verdict = VERDICT_VALID;
    end

    // ---------------- counters and result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonascii    <= 1'b0;
            r_len_cnt     <= '0;
            r_lower_cnt   <= '0;
            r_upper_cnt   <= '0;
            r_digit_cnt   <= '0;
            r_special_cnt <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_verdict.ready && !(s_proc && s_term)) begin
                r_out_valid <= 1'b0;
            end
            if (s_proc) begin
                if (s_term) begin
                    r_out_valid   <= 1'b1;
                    r_verdict     <= s_verdict;
                    r_len_out     <= s_len_sat;
                    r_nonascii    <= 1'b0;
                    r_len_cnt     <= '0;
                    r_lower_cnt   <= '0;
                    r_upper_cnt   <= '0;
                    r_digit_cnt   <= '0;
                    r_special_cnt <= '0;
                end else begin
                    r_len_cnt <= sat_inc(r_len_cnt);
                    priority if (s_high)
                        r_nonascii <= 1'b1;
                    else if (s_lower)
                        r_lower_cnt <= sat_inc(r_lower_cnt);
                    else if (s_upper)
                        r_upper_cnt <= sat_inc(r_upper_cnt);
                    else if (s_digit)
                        r_digit_cnt <= sat_inc(r_digit_cnt);
                    else if (s_punct)
                        r_special_cnt <= sat_inc(r_special_cnt);
                    else
                        ;
                end
            end
        end
    end

    assign o_verdict.valid         = r_out_valid;
    assign o_verdict.verdict       = r_verdict;
    assign o_verdict.string_length = r_len_out;

    // ---------------- assertions ----------------
    a_term_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_proc && s_term) |=> r_out_valid)
        else $error("terminator did not produce an item");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_proc && s_term) |=> (r_len_cnt == '0 && !r_nonascii))
        else $error("string state not cleared after terminator");

    a_class_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lower_cnt <= r_len_cnt) && (r_upper_cnt <= r_len_cnt) &&
        (r_digit_cnt <= r_len_cnt) && (r_special_cnt <= r_len_cnt))
        else $error("class count exceeds length count");

    a_no_item_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_proc && !s_term && !r_out_valid) |=> !r_out_valid)
        else $error("item produced for a non-terminator byte");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the password rule checker. Password bytes go in
// through the char channel, and verdicts are checked against a local copy of
// the counters and thresholds. It covers directed corner strings, register
// extremes, saturating counts, random passwords under changing thresholds,
// and random idling plus a long verdict stall.
// ----------------------------------------------------------------------------
module tb_top;
    import prc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_REGS     = 6;

    typedef struct packed {
        t_verdict         verdict;
        logic [LEN_W-1:0] length;
    } verdict_rec_t;

    typedef struct {
        logic       nonascii;
        logic [7:0] len_cnt;
        logic [7:0] lower_cnt;
        logic [7:0] upper_cnt;
        logic [7:0] digit_cnt;
        logic [7:0] punct_cnt;
    } pw_tally_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    prc_char_if    char_if ();
    prc_verdict_if vd_if ();

    password_rule_checker u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_char    (char_if),
        .o_verdict (vd_if)
    );

    // local copy of the block's state and thresholds
    pw_tally_t    tally;
    logic [7:0]   thresh [NUM_REGS];
    verdict_rec_t verdict_q [$];
    logic [7:0]   byte_q [$];

    int  src_idle_pct;
    int  sink_idle_pct;
    logic rx_hold;
    logic hold_go;
    int  errors;
    int  cycles;
    int  n_bytes;
    int  n_verdicts;
    int  n_reg_writes;
    logic [7:0] verdicts_seen;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic void clear_tally();
        tally.nonascii  = 1'b0;
        tally.len_cnt   = '0;
        tally.lower_cnt = '0;
        tally.upper_cnt = '0;
        tally.digit_cnt = '0;
        tally.punct_cnt = '0;
    endfunction

    function automatic void tally_byte(input logic [7:0] c);
        tally.len_cnt = sat_inc8(tally.len_cnt);
        if (c > ASCII_MAX)
            tally.nonascii = 1'b1;
        else if (c >= "a" && c <= "z")
            tally.lower_cnt = sat_inc8(tally.lower_cnt);
        else if (c >= "A" && c <= "Z")
            tally.upper_cnt = sat_inc8(tally.upper_cnt);
        else if (c >= "0" && c <= "9")
            tally.digit_cnt = sat_inc8(tally.digit_cnt);
        else if (is_punct(c))
            tally.punct_cnt = sat_inc8(tally.punct_cnt);
    endfunction

    function automatic verdict_rec_t judge_password();
        verdict_rec_t r;
        if (tally.nonascii)                               r.verdict = VERDICT_NONASCII;
        else if (tally.len_cnt < thresh[REG_MIN_LENGTH])  r.verdict = VERDICT_SHORT;
        else if (tally.len_cnt > thresh[REG_MAX_LENGTH])  r.verdict = VERDICT_LONG;
        else if (tally.lower_cnt < thresh[REG_MIN_LOWER]) r.verdict = VERDICT_LOWER;
        else if (tally.upper_cnt < thresh[REG_MIN_UPPER]) r.verdict = VERDICT_UPPER;
        else if (tally.digit_cnt < thresh[REG_MIN_DIGIT]) r.verdict = VERDICT_DIGITS;
        else if (tally.punct_cnt < thresh[REG_MIN_SPECIAL]) r.verdict = VERDICT_SPECIAL;
        else                                              r.verdict = VERDICT_VALID;
        r.length = tally.len_cnt;
        return r;
    endfunction

    // ---------------- byte driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_if.valid     <= 1'b0;
            char_if.char_byte <= '0;
        end else begin
            if (char_if.valid && char_if.ready) begin
                n_bytes++;
                if (char_if.char_byte != 8'h00) begin
                    tally_byte(char_if.char_byte);
                end else begin
                    verdict_q.push_back(judge_password());
                    clear_tally();
                end
            end
            if (!char_if.valid || char_if.ready) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    char_if.valid     <= 1'b1;
                    char_if.char_byte <= byte_q.pop_front();
                end else begin
                    char_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- verdict monitor ----------------
    always @(posedge i_clk) begin : verdict_mon
        verdict_rec_t want;
        if (!i_rst_n) begin
            vd_if.ready <= 1'b0;
        end else begin
            vd_if.ready <= !rx_hold && ($urandom_range(99) >= sink_idle_pct);
            if (vd_if.valid && vd_if.ready) begin
                n_verdicts++;
                if (verdict_q.size() == 0) begin
                    $error("unexpected verdict %0d, length %0d",
                           vd_if.verdict, vd_if.string_length);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    verdicts_seen[want.verdict] = 1'b1;
                    if (vd_if.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, vd_if.verdict);
                        errors++;
                    end
                    if (vd_if.string_length !== want.length) begin
                        $error("string_length: expected %0d, got %0d",
                               want.length, vd_if.string_length);
                        errors++;
                    end
                end
            end
        end
    end

    // long verdict stall, counted here so the sender keeps going meanwhile
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ---------------- stimulus helpers ----------------
    task automatic push_char(input logic [7:0] c);
        byte_q.push_back(c);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) push_char(s[k]);
        push_char(8'h00);
    endtask

    task automatic push_run(input logic [7:0] c, input int n);
        for (int k = 0; k < n; k++) push_char(c);
    endtask

    function automatic logic [7:0] pick_punct();
        int r;
        r = $urandom_range(31);
        if (r < 15) return 8'(33 + r);
        if (r < 22) return 8'(58 + r - 15);
        if (r < 28) return 8'(91 + r - 22);
        return 8'(123 + r - 28);
    endfunction

    function automatic logic [7:0] random_pw_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 8'($urandom_range("z", "a"));
        if (r < 50) return 8'($urandom_range("Z", "A"));
        if (r < 65) return 8'($urandom_range("9", "0"));
        if (r < 80) return pick_punct();
        if (r < 87) return 8'($urandom_range(32, 1));
        if (r < 89) return 8'd127;
        if (r < 93) return 8'($urandom_range(255, 128));
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic push_random_password(input int max_len);
        int n;
        n = ($urandom_range(19) == 0) ? $urandom_range(2 * max_len) : $urandom_range(max_len);
        for (int k = 0; k < n; k++) push_char(random_pw_byte());
        push_char(8'h00);
    endtask

    task automatic set_idle(input int src_pct, input int sink_pct);
        src_idle_pct  <= src_pct;
        sink_idle_pct <= sink_pct;
    endtask

    // all bytes taken, all verdicts back, then let the pipe settle
    task automatic drain_results();
        @(posedge i_clk);
        while (byte_q.size() != 0 || char_if.valid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_reg_writes++;
        if (idx < NUM_REGS) thresh[idx] = val;
    endtask

    task automatic check_regs();
        for (int k = 0; k < NUM_REGS; k++) begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(k), 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata[7:0] !== thresh[k]) begin
                $error("prdata: expected %0d, got %0d (reg %0d)", thresh[k], prdata[7:0], k);
                errors++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic write_all(input logic [7:0] mn_len, input logic [7:0] mx_len,
                             input logic [7:0] lo, input logic [7:0] up,
                             input logic [7:0] dg, input logic [7:0] sp);
        write_reg(REG_MIN_LENGTH, mn_len);
        write_reg(REG_MAX_LENGTH, mx_len);
        write_reg(REG_MIN_LOWER, lo);
        write_reg(REG_MIN_UPPER, up);
        write_reg(REG_MIN_DIGIT, dg);
        write_reg(REG_MIN_SPECIAL, sp);
        check_regs();
    endtask

    task automatic random_phase(input int n);
        int start;
        write_all(8'($urandom_range(10)), 8'($urandom_range(24, 6)),
                  8'($urandom_range(3)), 8'($urandom_range(3)),
                  8'($urandom_range(3)), 8'($urandom_range(3)));
        start = byte_q.size();
        while (byte_q.size() - start < n) push_random_password(20);
        drain_results();
    endtask

    // ---------------- main sequence ----------------
    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        char_if.valid     = 1'b0;
        char_if.char_byte = '0;
        vd_if.ready       = 1'b0;
        hold_go           = 1'b0;
        src_idle_pct      = 10;
        sink_idle_pct     = 46;
        errors            = 0;
        cycles            = 0;
        n_bytes           = 0;
        n_verdicts        = 0;
        n_reg_writes      = 0;
        verdicts_seen     = '0;
        thresh[REG_MIN_LENGTH]  = RST_MIN_LENGTH;
        thresh[REG_MAX_LENGTH]  = RST_MAX_LENGTH;
        thresh[REG_MIN_LOWER]   = RST_MIN_LOWER;
        thresh[REG_MIN_UPPER]   = RST_MIN_UPPER;
        thresh[REG_MIN_DIGIT]   = RST_MIN_DIGIT;
        thresh[REG_MIN_SPECIAL] = RST_MIN_SPECIAL;
        clear_tally();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings against reset thresholds
        check_regs();
        push_text("");
        push_text("Aa1!aaaa");
        push_text("Aa1!");
        push_run("a", 67);
        push_text("A1!");
        push_text("aaaaaaa1!");
        push_text("AAAAAAA1!");
        push_text("AAAAaaaa!");
        push_text("AAAAaaaa1");
        push_char(8'h60);
        push_text("Zz09/:@[{~ ");
        push_char(8'd1);
        push_char(8'd31);
        push_char(8'd127);
        push_text("Aa1!aaaa");
        push_char(8'h80);
        push_text("Aa1!aaaa");
        push_char(8'hFF);
        push_text("a");
        drain_results();

        // zero thresholds: only the empty string fits max_length 0
        write_all(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        write_reg(REG_RSVD_6, 8'($urandom));
        write_reg(REG_RSVD_7, 8'($urandom));
        push_text("");
        push_text("a");
        push_char(8'hA5);
        push_char(8'h00);
        drain_results();

        // top of range, counters saturated
        write_all(8'd254, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255);
        push_run("!", 280);
        push_char(8'h00);
        push_run("!", 254);
        push_char(8'h00);
        push_text("Aa1!");
        drain_results();
        write_reg(REG_MAX_LENGTH, 8'd254);
        write_reg(REG_MIN_LENGTH, 8'd255);
        push_run("a", 270);
        push_char(8'h00);
        push_run("Q", 255);
        push_char(8'h00);
        drain_results();

        // random passwords under changing thresholds and idling
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2)      set_idle(10, 46);
            else if (ph < 4) set_idle(46, 10);
            else             set_idle(0, 0);
            if (ph == 5) hold_go = 1'b1;
            random_phase(20);
        end

        // back to reset thresholds for a last random burst
        write_all(RST_MIN_LENGTH, RST_MAX_LENGTH, RST_MIN_LOWER, RST_MIN_UPPER,
                  RST_MIN_DIGIT, RST_MIN_SPECIAL);
        set_idle(20, 20);
        for (int k = 0; k < 20; k++) push_random_password(14);
        drain_results();

        $display("tb: %0d bytes in, %0d verdicts checked, %0d register writes",
                 n_bytes, n_verdicts, n_reg_writes);
        $display("tb: verdict codes seen (bit per code) %b", verdicts_seen);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/prc_pkg.sv
rtl/prc_char_if.sv
rtl/prc_verdict_if.sv
rtl/password_rule_checker.sv
verif/tb_top.sv
